FILE: src/msir_pkg.sv
// Shared constants and types of the material submesh index remapper.
`default_nettype none

package msir_pkg;

    // Table sizes
    localparam int MAX_VERTICES  = 65536;
    localparam int VTX_AW        = $clog2(MAX_VERTICES);
    localparam int MAX_SUBMESHES = 256;
    localparam int SLOT_AW       = $clog2(MAX_SUBMESHES);
    localparam int TOTAL_W       = SLOT_AW + 1;
    localparam int COUNT_W       = VTX_AW + 1;
    localparam int MATERIAL_IDS  = 256;

    // Port field widths
    localparam int INDEX_W    = 32;
    localparam int MAT_W      = 8;
    localparam int CFG_W      = 17;
    localparam int SLOT_OUT_W = 8;
    localparam int LOCAL_W    = 16;

    // Generation tags of the vertex table; the all-zero tag never matches.
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic              start;
        logic              in_range;
        logic [VTX_AW-1:0] vidx;
        logic [MAT_W-1:0]  mat;
    } q_item_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [VTX_AW-1:0]  local_idx;
    } vtx_entry_t;

endpackage

`default_nettype wire

FILE: src/msir_front.sv
// Front part: holds the vertex count register and classifies incoming beats.
`default_nettype none

module msir_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [msir_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [msir_pkg::INDEX_W-1:0]  vertex_index,
    input  wire logic [msir_pkg::MAT_W-1:0]    mat_id,
    input  wire logic                          mesh_start,
    input  wire logic                          q_full,
    output logic                               q_push,
    output msir_pkg::q_item_t                  q_item
);

    logic [msir_pkg::CFG_W-1:0] vertex_count_reg;
    logic                       below_count;
    logic                       below_max;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            vertex_count_reg <= cfg_wdata;
        end
    end

    // An index is handled only when it lies below both the programmed count
    // and the table depth.
    assign below_count = vertex_index < msir_pkg::INDEX_W'(vertex_count_reg);
    assign below_max   = vertex_index < msir_pkg::INDEX_W'(msir_pkg::MAX_VERTICES);

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.start    = mesh_start;
        q_item.in_range = below_count && below_max;
        q_item.vidx     = vertex_index[msir_pkg::VTX_AW-1:0];
        q_item.mat      = mat_id;
    end

endmodule

`default_nettype wire

FILE: src/msir_queue.sv
// Short queue of classified beats between the front and the back.
`default_nettype none

module msir_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire msir_pkg::q_item_t push_item,
    output logic                   full,
    input  wire logic              pop,
    output logic                   empty,
    output msir_pkg::q_item_t      head
);

    localparam logic [msir_pkg::QUEUE_AW-1:0] LAST_PTR =
        msir_pkg::QUEUE_AW'(msir_pkg::QUEUE_DEPTH - 1);

    msir_pkg::q_item_t                store_reg [msir_pkg::QUEUE_DEPTH];
    logic [msir_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [msir_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [msir_pkg::QUEUE_AW:0]      fill_reg;

    function automatic logic [msir_pkg::QUEUE_AW-1:0] bump(
        input logic [msir_pkg::QUEUE_AW-1:0] ptr);
        if (ptr == LAST_PTR)
            return '0;
        return ptr + 1'b1;
    endfunction

    assign full  = fill_reg == (msir_pkg::QUEUE_AW + 1)'(msir_pkg::QUEUE_DEPTH);
    assign empty = fill_reg == '0;
    assign head  = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/msir_back.sv
// Back part: table lookups, slot and local index allocation, result register.
`default_nettype none

module msir_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_empty,
    input  wire msir_pkg::q_item_t                 q_head,
    output logic                                   q_pop,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [msir_pkg::SLOT_OUT_W-1:0]        submesh_slot,
    output logic                                   new_submesh,
    output logic [msir_pkg::LOCAL_W-1:0]           local_index,
    output logic                                   new_vertex,
    output logic [msir_pkg::LOCAL_W-1:0]           source_vertex
);

    typedef enum logic [2:0] {
        S_WIPE,
        S_IDLE,
        S_RELOOK,
        S_FETCH,
        S_COUNT
    } state_t;

    localparam logic [msir_pkg::VTX_AW-1:0] WIPE_LAST =
        msir_pkg::VTX_AW'(msir_pkg::MAX_VERTICES - 1);
    localparam logic [msir_pkg::TOTAL_W-1:0] TOTAL_FULL =
        msir_pkg::TOTAL_W'(msir_pkg::MAX_SUBMESHES);

    state_t                                 state_reg;
    msir_pkg::q_item_t                      cur_reg;
    logic                                   pend_reg;
    logic [msir_pkg::VTX_AW-1:0]            wipe_reg;
    logic [msir_pkg::EPOCH_W-1:0]           epoch_reg;
    logic [msir_pkg::TOTAL_W-1:0]           total_reg;
    logic [msir_pkg::MATERIAL_IDS-1:0]      mat_valid_reg;
    logic [msir_pkg::SLOT_AW-1:0]           slot_reg;
    logic                                   new_sub_reg;
    logic                                   hit_reg;
    logic [msir_pkg::VTX_AW-1:0]            hit_local_reg;

    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic [msir_pkg::SLOT_OUT_W-1:0]        out_slot_reg;
    logic                                   out_new_sub_reg;
    logic [msir_pkg::LOCAL_W-1:0]           out_local_reg;
    logic                                   out_new_vtx_reg;
    logic [msir_pkg::LOCAL_W-1:0]           out_source_reg;

    // Table memories
    logic [msir_pkg::SLOT_AW-1:0]   mat_mem [msir_pkg::MATERIAL_IDS];
    logic [msir_pkg::SLOT_AW-1:0]   mat_rd_reg;
    msir_pkg::vtx_entry_t           vtx_mem [msir_pkg::MAX_VERTICES];
    msir_pkg::vtx_entry_t           vtx_rd_reg;
    logic [msir_pkg::COUNT_W-1:0]   cnt_mem [msir_pkg::MAX_SUBMESHES];
    logic [msir_pkg::COUNT_W-1:0]   cnt_rd_reg;

    msir_pkg::q_item_t              rd_item;
    logic                           mat_hit;
    logic                           vtx_hit;
    logic                           exhausted;
    logic [msir_pkg::SLOT_AW-1:0]   fetch_slot;
    logic [msir_pkg::COUNT_W-1:0]   count_now;
    logic [msir_pkg::VTX_AW-1:0]    local_now;
    logic                           out_free;
    logic                           commit;
    logic                           vtx_we;
    logic [msir_pkg::VTX_AW-1:0]    vtx_waddr;
    msir_pkg::vtx_entry_t           vtx_wdata;

    assign rd_item    = (state_reg == S_IDLE) ? q_head : cur_reg;
    assign mat_hit    = mat_valid_reg[cur_reg.mat];
    assign vtx_hit    = vtx_rd_reg.tag == epoch_reg;
    assign exhausted  = !mat_hit && (total_reg == TOTAL_FULL);
    assign fetch_slot = mat_hit ? mat_rd_reg : total_reg[msir_pkg::SLOT_AW-1:0];
    // A freshly opened slot has appended nothing in this mesh yet.
    assign count_now  = new_sub_reg ? '0 : cnt_rd_reg;
    assign local_now  = hit_reg ? hit_local_reg : count_now[msir_pkg::VTX_AW-1:0];
    assign out_free   = !out_valid_reg || !out_stall;
    assign q_pop      = (state_reg == S_IDLE) && !q_empty;
    assign commit     = (state_reg == S_COUNT) && out_free;
    // The result register stays full while stalled and is refilled on a commit.
    assign out_valid_next = commit || (out_valid_reg && out_stall);

    always_comb
    begin
        vtx_we    = 1'b0;
        vtx_waddr = cur_reg.vidx;
        vtx_wdata.tag       = epoch_reg;
        vtx_wdata.local_idx = local_now;
        if (state_reg == S_WIPE)
        begin
            vtx_we              = 1'b1;
            vtx_waddr           = wipe_reg;
            vtx_wdata.tag       = msir_pkg::EPOCH_NONE;
            vtx_wdata.local_idx = '0;
        end
        else if (commit && !hit_reg)
        begin
            vtx_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vtx_we)
        begin
            vtx_mem[vtx_waddr] <= vtx_wdata;
        end
        vtx_rd_reg <= vtx_mem[rd_item.vidx];
    end

    always_ff @(posedge clk)
    begin
        if (commit && new_sub_reg)
        begin
            mat_mem[cur_reg.mat] <= slot_reg;
        end
        mat_rd_reg <= mat_mem[rd_item.mat];
    end

    // A newly opened slot always gets its count written, so that a count left over
    // from an earlier mesh is never read back.
    always_ff @(posedge clk)
    begin
        if (commit && (new_sub_reg || !hit_reg))
        begin
            cnt_mem[slot_reg] <= count_now + msir_pkg::COUNT_W'(!hit_reg);
        end
        cnt_rd_reg <= cnt_mem[fetch_slot];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_WIPE;
            cur_reg         <= '0;
            pend_reg        <= 1'b0;
            wipe_reg        <= '0;
            epoch_reg       <= msir_pkg::EPOCH_FIRST;
            total_reg       <= '0;
            mat_valid_reg   <= '0;
            slot_reg        <= '0;
            new_sub_reg     <= 1'b0;
            hit_reg         <= 1'b0;
            hit_local_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_slot_reg    <= '0;
            out_new_sub_reg <= 1'b0;
            out_local_reg   <= '0;
            out_new_vtx_reg <= 1'b0;
            out_source_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;

            unique case (state_reg)
                S_WIPE:
                begin
                    wipe_reg <= wipe_reg + 1'b1;
                    if (wipe_reg == WIPE_LAST)
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= pend_reg ? S_RELOOK : S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        cur_reg <= q_head;
                        if (q_head.start)
                        begin
                            mat_valid_reg <= '0;
                            total_reg     <= '0;
                        end
                        if (q_head.start && (epoch_reg == msir_pkg::EPOCH_LAST))
                        begin
                            epoch_reg <= msir_pkg::EPOCH_FIRST;
                            wipe_reg  <= '0;
                            pend_reg  <= q_head.in_range;
                            state_reg <= S_WIPE;
                        end
                        else
                        begin
                            state_reg <= q_head.in_range ? S_FETCH : S_IDLE;
                            if (q_head.start)
                            begin
                                epoch_reg <= epoch_reg + 1'b1;
                            end
                        end
                    end
                end

                S_RELOOK:
                begin
                    state_reg <= S_FETCH;
                end

                S_FETCH:
                begin
                    if (exhausted)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        slot_reg      <= fetch_slot;
                        new_sub_reg   <= !mat_hit;
                        hit_reg       <= vtx_hit;
                        hit_local_reg <= vtx_rd_reg.local_idx;
                        state_reg     <= S_COUNT;
                    end
                end

                S_COUNT:
                begin
                    if (out_free)
                    begin
                        if (new_sub_reg)
                        begin
                            mat_valid_reg[cur_reg.mat] <= 1'b1;
                            total_reg                  <= total_reg + 1'b1;
                        end
                        out_slot_reg    <= msir_pkg::SLOT_OUT_W'(slot_reg);
                        out_new_sub_reg <= new_sub_reg;
                        out_local_reg   <= msir_pkg::LOCAL_W'(local_now);
                        out_new_vtx_reg <= !hit_reg;
                        out_source_reg  <= msir_pkg::LOCAL_W'(cur_reg.vidx);
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign submesh_slot  = out_slot_reg;
    assign new_submesh   = out_new_sub_reg;
    assign local_index   = out_local_reg;
    assign new_vertex    = out_new_vtx_reg;
    assign source_vertex = out_source_reg;

endmodule

`default_nettype wire

FILE: src/material_submesh_index_remap.sv
// Top level of the material submesh index remapper.
//
//  Channel   Signals                                  Direction  Beat when
//  -------   ---------------------------------------  ---------  --------------------
//  in        in_valid, in_stall, vertex_index,         into       in_valid & !in_stall
//            mat_id, mesh_start
//  out       out_valid, out_stall, submesh_slot,       out of     out_valid & !out_stall
//            new_submesh, local_index, new_vertex,
//            source_vertex
//  cfg       cfg_we, cfg_wdata (vertex_count)          into       cfg_we
//
// Each beat in range passes a table read, a count read and a commit in the back part,
// as the slot read must finish before the per-slot count can be read; a beat out of range
// ends at the table read and a beat dropped for want of a free slot at the count read.
// After reset the vertex table is swept once over all 65536 entries, and the sweep runs
// again on every 255th mesh start, when the generation tag wraps; a held beat in range
// reads the tables again after that sweep. The front accepts into a two-entry queue and
// raises in_stall only when it is full. A stalled out beat holds the commit and the next pop.
`default_nettype none

module material_submesh_index_remap (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [msir_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [msir_pkg::INDEX_W-1:0]      vertex_index,
    input  wire logic [msir_pkg::MAT_W-1:0]        mat_id,
    input  wire logic                              mesh_start,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [msir_pkg::SLOT_OUT_W-1:0]        submesh_slot,
    output logic                                   new_submesh,
    output logic [msir_pkg::LOCAL_W-1:0]           local_index,
    output logic                                   new_vertex,
    output logic [msir_pkg::LOCAL_W-1:0]           source_vertex
);

    // Classified beats pass from the front through the queue to the back.
    logic              q_full;
    logic              q_push;
    logic              q_empty;
    logic              q_pop;
    msir_pkg::q_item_t q_item;
    msir_pkg::q_item_t q_head;

    // The front checks the index against the vertex count at acceptance time.
    msir_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .vertex_index (vertex_index),
        .mat_id       (mat_id),
        .mesh_start   (mesh_start),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (q_item)
    );

    msir_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // The back owns all tables and the output register, and handles one beat at a time.
    msir_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .submesh_slot  (submesh_slot),
        .new_submesh   (new_submesh),
        .local_index   (local_index),
        .new_vertex    (new_vertex),
        .source_vertex (source_vertex)
    );

endmodule

`default_nettype wire
